@@ rtl/region_switch_button_controller_core_assert.svh @@
// Assertion macros for the region switch button controller.
// Used at the end of the top level; needs clk and rst in scope.
`ifndef REGION_SWITCH_BUTTON_CONTROLLER_CORE_ASSERT_SVH
`define REGION_SWITCH_BUTTON_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsbc assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RSBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsbc assertion failed one cycle later");

`endif

@@ rtl/rsbc_pkg.sv @@
// Shared types, constants and helper functions of the region switch button controller.
// No dependencies.
package rsbc_pkg;

  localparam int DebounceTicksDefault = 3;
  localparam int HoldCountBitsDefault = 16;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 16;

  localparam logic [CfgIndexBits-1:0] REG_ADDON_MODE         = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_LED_COMMON_ANODE   = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_HOLD_TICKS         = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_FAST_BLINK_TICKS   = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_SLOW_BLINK_TICKS   = 3'd4;
  localparam logic [CfgIndexBits-1:0] REG_RESET_PULSE_TICKS  = 3'd5;
  localparam logic [CfgIndexBits-1:0] REG_SHOW_STEP_LIMIT    = 3'd6;
  localparam logic [CfgIndexBits-1:0] REG_CONFIRM_STEP_LIMIT = 3'd7;

  localparam logic [1:0] REGION_JAPAN  = 2'd0;
  localparam logic [1:0] REGION_EUROPE = 2'd1;
  localparam logic [1:0] REGION_USA    = 2'd2;

  typedef struct packed {
    logic        addon_mode;
    logic        led_common_anode;
    logic [15:0] hold_ticks;
    logic [7:0]  fast_blink_ticks;
    logic [7:0]  slow_blink_ticks;
    logic [7:0]  reset_pulse_ticks;
    logic [4:0]  show_step_limit;
    logic [4:0]  confirm_step_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    addon_mode:         1'b0,
    led_common_anode:   1'b1,
    hold_ticks:         16'd152,
    fast_blink_ticks:   8'd8,
    slow_blink_ticks:   8'd16,
    reset_pulse_ticks:  8'd16,
    show_step_limit:    5'd8,
    confirm_step_limit: 5'd5
  };

  typedef struct packed {
    logic       cmd;
    logic       tick;
    logic       button_edge;
    logic       button_pressed;
    logic [7:0] saved_value;
  } in_item_t;

  typedef struct packed {
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic       video_pin;
    logic       language_pin;
    logic       inv_video_pin;
    logic       inv_language_pin;
    logic       reset_out;
    logic       save_strobe;
    logic [1:0] current_region;
  } out_item_t;

  typedef struct packed {
    logic [1:0] region_sel;
    logic       press_active;
    logic       show_mode;
    logic       confirm_mode;
    logic       reset_active;
    logic       blink_phase;
    logic [4:0] step_count;
    logic [7:0] wait_count;
    logic [1:0] debounce_count;
    logic [2:0] led_pattern;
    logic [3:0] region_pins;
    logic       reset_pin;
  } state_t;

  localparam state_t STATE_RESET = '{
    region_sel:     REGION_EUROPE,
    press_active:   1'b0,
    show_mode:      1'b0,
    confirm_mode:   1'b0,
    reset_active:   1'b0,
    blink_phase:    1'b1,
    step_count:     5'd0,
    wait_count:     8'd0,
    debounce_count: 2'd0,
    led_pattern:    3'd0,
    region_pins:    4'd0,
    reset_pin:      1'b1
  };

  // One-hot LED pattern for a region; an invalid code lights nothing.
  function automatic logic [2:0] lit_for(input logic [1:0] region);
    logic [2:0] lit;
    case (region)
      REGION_JAPAN:  lit = 3'b001;
      REGION_EUROPE: lit = 3'b010;
      REGION_USA:    lit = 3'b100;
      default:       lit = 3'b000;
    endcase
    return lit;
  endfunction

  // Region that follows in show mode, matching (region + 1) mod 3.
  function automatic logic [1:0] region_after(input logic [1:0] region);
    logic [1:0] nxt;
    case (region)
      REGION_JAPAN:  nxt = REGION_EUROPE;
      REGION_EUROPE: nxt = REGION_USA;
      REGION_USA:    nxt = REGION_JAPAN;
      default:       nxt = REGION_EUROPE;
    endcase
    return nxt;
  endfunction

  // Byte modulo 3 by folding base-4 digits, since 4 is 1 modulo 3.
  function automatic logic [1:0] mod3(input logic [7:0] value);
    logic [3:0] sum4;
    logic [2:0] sum3;
    sum4 = 4'(value[1:0]) + 4'(value[3:2]) + 4'(value[5:4]) + 4'(value[7:6]);
    sum3 = 3'(sum4[1:0]) + 3'(sum4[3:2]);
    if (sum3 >= 3'd3) begin
      sum3 = sum3 - 3'd3;
    end
    return sum3[1:0];
  endfunction

  // Drives the region pins and, in add-on mode, starts a reset pulse.
  function automatic state_t apply_region(input state_t st, input cfg_t cfg);
    state_t s;
    s = st;
    if (cfg.addon_mode) begin
      s.reset_pin    = 1'b0;
      s.reset_active = 1'b1;
      s.wait_count   = cfg.reset_pulse_ticks;
    end
    case (s.region_sel)
      REGION_JAPAN:  s.region_pins = 4'b1001;
      REGION_EUROPE: s.region_pins = 4'b0110;
      REGION_USA:    s.region_pins = 4'b0011;
      default:       s.region_pins = st.region_pins;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/rsbc_stream_if.sv @@
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from rsbc_pkg.
interface rsbc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rsbc_cfg.sv @@
// Configuration register file of the region switch button controller.
// Depends on rsbc_pkg for the register layout, indexes and reset values.
module rsbc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rsbc_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [rsbc_pkg::CfgDataBits-1:0]  cfg_data,
  output rsbc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= rsbc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rsbc_pkg::REG_ADDON_MODE:         cfg.addon_mode         <= cfg_data[0];
        rsbc_pkg::REG_LED_COMMON_ANODE:   cfg.led_common_anode   <= cfg_data[0];
        rsbc_pkg::REG_HOLD_TICKS:         cfg.hold_ticks         <= cfg_data;
        rsbc_pkg::REG_FAST_BLINK_TICKS:   cfg.fast_blink_ticks   <= cfg_data[7:0];
        rsbc_pkg::REG_SLOW_BLINK_TICKS:   cfg.slow_blink_ticks   <= cfg_data[7:0];
        rsbc_pkg::REG_RESET_PULSE_TICKS:  cfg.reset_pulse_ticks  <= cfg_data[7:0];
        rsbc_pkg::REG_SHOW_STEP_LIMIT:    cfg.show_step_limit    <= cfg_data[4:0];
        rsbc_pkg::REG_CONFIRM_STEP_LIMIT: cfg.confirm_step_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/rsbc_step.sv @@
// Combinational next-state and result logic for one polling pass.
// Depends on rsbc_pkg for the state, config and item types and helper functions.
module rsbc_step #(
  parameter int DebounceTicks = rsbc_pkg::DebounceTicksDefault,
  parameter int HoldCountBits = rsbc_pkg::HoldCountBitsDefault
) (
  input  rsbc_pkg::state_t     st,
  input  logic [HoldCountBits-1:0] hold_count,
  input  rsbc_pkg::cfg_t       cfg,
  input  rsbc_pkg::in_item_t   item,
  output rsbc_pkg::state_t     st_next,
  output logic [HoldCountBits-1:0] hold_count_next,
  output rsbc_pkg::out_item_t  result
);

  localparam int CmpBits = (HoldCountBits > 16) ? HoldCountBits : 16;

  rsbc_pkg::state_t          s;
  logic [HoldCountBits-1:0]  hc;
  logic                      applied;
  logic                      long_hold;
  logic [2:0]                pins_led;

  always_comb begin
    s       = st;
    hc      = hold_count;
    applied = 1'b0;
    long_hold = 1'b0;
    if (item.cmd) begin
      s.region_sel  = rsbc_pkg::mod3(item.saved_value);
      s             = rsbc_pkg::apply_region(s, cfg);
      s.led_pattern = rsbc_pkg::lit_for(s.region_sel);
    end else begin
      if (item.button_edge && s.debounce_count == 2'd0) begin
        s.debounce_count = 2'(DebounceTicks);
        s.press_active   = 1'b1;
      end
      if (item.tick) begin
        if (s.press_active && !(&hc)) begin
          hc = hc + HoldCountBits'(1);
        end
        if (s.debounce_count != 2'd0) begin
          s.debounce_count = s.debounce_count - 2'd1;
        end
        if (s.wait_count != 8'd0) begin
          s.wait_count = s.wait_count - 8'd1;
        end
      end
      long_hold = CmpBits'(hc) > CmpBits'(cfg.hold_ticks);
      if (s.press_active && s.debounce_count == 2'd0) begin
        if (item.button_pressed) begin
          if (long_hold) begin
            s.show_mode = 1'b1;
          end
        end else begin
          s.press_active = 1'b0;
          if (long_hold) begin
            s.step_count   = 5'd0;
            s.show_mode    = 1'b0;
            s.confirm_mode = 1'b1;
          end else begin
            s.reset_active = 1'b1;
            s.wait_count   = cfg.reset_pulse_ticks;
          end
          hc = '0;
        end
      end
      if (s.show_mode && s.wait_count == 8'd0) begin
        s.led_pattern = s.blink_phase ? rsbc_pkg::lit_for(s.region_sel) : 3'b000;
        if (s.step_count > cfg.show_step_limit) begin
          s.step_count = 5'd0;
          s.region_sel = rsbc_pkg::region_after(s.region_sel);
        end else begin
          s.step_count = s.step_count + 5'd1;
        end
        s.blink_phase = ~s.blink_phase;
        s.wait_count  = cfg.fast_blink_ticks;
      end
      if (s.confirm_mode && s.wait_count == 8'd0) begin
        s.led_pattern = s.blink_phase ? rsbc_pkg::lit_for(s.region_sel) : 3'b000;
        if (s.step_count > cfg.confirm_step_limit) begin
          s.step_count   = 5'd0;
          s.confirm_mode = 1'b0;
          s.led_pattern  = rsbc_pkg::lit_for(s.region_sel);
          s              = rsbc_pkg::apply_region(s, cfg);
          applied        = 1'b1;
        end else begin
          s.step_count = s.step_count + 5'd1;
        end
        s.blink_phase = ~s.blink_phase;
        s.wait_count  = cfg.slow_blink_ticks;
      end
      if (s.reset_active) begin
        if (s.wait_count != 8'd0) begin
          s.reset_pin = 1'b0;
        end else begin
          s.reset_pin    = 1'b1;
          s.reset_active = 1'b0;
        end
      end
    end
  end

  assign pins_led        = s.led_pattern ^ {3{cfg.led_common_anode}};
  assign st_next         = s;
  assign hold_count_next = hc;

  assign result = '{
    led_red:          pins_led[0],
    led_green:        pins_led[1],
    led_blue:         pins_led[2],
    video_pin:        s.region_pins[0],
    language_pin:     s.region_pins[1],
    inv_video_pin:    s.region_pins[2],
    inv_language_pin: s.region_pins[3],
    reset_out:        s.reset_pin,
    save_strobe:      applied,
    current_region:   s.region_sel
  };

endmodule

@@ rtl/region_switch_button_controller_core.sv @@
// Structure: two register stages, the input register and the result register;
// an accepted item waits in the input register until the result register is free.
// Throughput: one transaction per cycle while results.ready is held high; the
// state update between the input and result registers is combinational.
// Reset: synchronous rst clears all control state and restores the register
// defaults; no clearing pass is needed.
`include "region_switch_button_controller_core_assert.svh"

module region_switch_button_controller_core #(
  parameter int DebounceTicks = rsbc_pkg::DebounceTicksDefault,
  parameter int HoldCountBits = rsbc_pkg::HoldCountBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rsbc_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [rsbc_pkg::CfgDataBits-1:0]  cfg_data,
  rsbc_stream_if.sink                       items,
  rsbc_stream_if.source                     results
);

  rsbc_pkg::cfg_t            cfg;
  logic                      in_valid;
  rsbc_pkg::in_item_t        in_item;
  logic                      out_valid;
  rsbc_pkg::out_item_t       out_item;
  rsbc_pkg::state_t          state;
  rsbc_pkg::state_t          state_next;
  logic [HoldCountBits-1:0]  hold_count;
  logic [HoldCountBits-1:0]  hold_count_next;
  rsbc_pkg::out_item_t       result_next;
  logic                      advance;

  rsbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsbc_step #(
    .DebounceTicks (DebounceTicks),
    .HoldCountBits (HoldCountBits)
  ) u_step (
    .st              (state),
    .hold_count      (hold_count),
    .cfg             (cfg),
    .item            (in_item),
    .st_next         (state_next),
    .hold_count_next (hold_count_next),
    .result          (result_next)
  );

  assign advance         = in_valid && (!out_valid || results.ready);
  assign items.ready     = !in_valid || advance;
  assign results.valid   = out_valid;
  assign results.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item <= items.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      state      <= rsbc_pkg::STATE_RESET;
      hold_count <= '0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        state      <= state_next;
        hold_count <= hold_count_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result_next;
    end
  end

  `RSBC_ASSERT_SAME(a_region_valid, 1'b1, state.region_sel != 2'd3)
  `RSBC_ASSERT_SAME(a_save_drives_pins, out_valid && out_item.save_strobe, (out_item.video_pin || out_item.language_pin))
  `RSBC_ASSERT_NEXT(a_advance_gives_result, advance, out_valid)
  `RSBC_ASSERT_SAME(a_reset_pulse_tracked, !state.reset_pin, state.reset_active)

endmodule

@@ tb/tb_region_switch_button_controller_core.sv @@
// Self-checking testbench for region_switch_button_controller_core.
// Predicts every result from its own model of the selector and checks it field by field.
// Depends on rsbc_pkg and rsbc_stream_if from the RTL.
`timescale 1ns / 1ps

module tb_region_switch_button_controller_core;

  localparam logic [1:0]  DEBOUNCE_PASSES = 2'd3;
  localparam logic [15:0] HOLD_FULL       = 16'hFFFF;
  localparam int          InItemBits      = $bits(rsbc_pkg::in_item_t);

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [rsbc_pkg::CfgIndexBits-1:0] cfg_index;
  logic [rsbc_pkg::CfgDataBits-1:0]  cfg_data;

  rsbc_stream_if #(.T(rsbc_pkg::in_item_t))  item_ch ();
  rsbc_stream_if #(.T(rsbc_pkg::out_item_t)) res_ch ();

  region_switch_button_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (res_ch)
  );

  rsbc_pkg::cfg_t shadow_cfg = '{1'b0, 1'b1, 16'd152, 8'd8, 8'd16, 8'd16, 5'd8, 5'd5};

  logic [1:0]  region     = rsbc_pkg::REGION_EUROPE;
  logic        pressing   = 1'b0;
  logic        showing    = 1'b0;
  logic        confirming = 1'b0;
  logic        pulsing    = 1'b0;
  logic        phase      = 1'b1;
  logic [4:0]  steps      = 5'd0;
  logic [7:0]  delay      = 8'd0;
  logic [1:0]  bounce     = 2'd0;
  logic [15:0] held       = 16'd0;
  logic [2:0]  lamps      = 3'd0;
  logic [3:0]  pins       = 4'd0;
  logic        rst_line   = 1'b1;

  rsbc_pkg::out_item_t expected_outputs[$];
  int                  mismatches  = 0;
  int                  passes_sent = 0;
  bit                  idle_on     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [2:0] lamp_of(input logic [1:0] r);
    return (r == rsbc_pkg::REGION_JAPAN) ? 3'b001 :
           (r == rsbc_pkg::REGION_EUROPE) ? 3'b010 :
           (r == rsbc_pkg::REGION_USA) ? 3'b100 : 3'b000;
  endfunction

  task automatic apply_pins();
    if (shadow_cfg.addon_mode) begin
      rst_line = 1'b0;
      pulsing  = 1'b1;
      delay    = shadow_cfg.reset_pulse_ticks;
    end
    case (region)
      rsbc_pkg::REGION_JAPAN:  pins = 4'b1001;
      rsbc_pkg::REGION_EUROPE: pins = 4'b0110;
      rsbc_pkg::REGION_USA:    pins = 4'b0011;
      default: ;
    endcase
  endtask

  task automatic blink_step(input logic [4:0] limit, input bit advance, inout logic strobe);
    lamps = phase ? lamp_of(region) : 3'b000;
    if (steps > limit) begin
      steps = 5'd0;
      if (advance) begin
        region = (region == rsbc_pkg::REGION_USA) ? rsbc_pkg::REGION_JAPAN : region + 2'd1;
      end else begin
        confirming = 1'b0;
        lamps      = lamp_of(region);
        apply_pins();
        strobe = 1'b1;
      end
    end else begin
      steps = steps + 5'd1;
    end
    phase = ~phase;
  endtask

  task automatic update_selector(input rsbc_pkg::in_item_t it);
    rsbc_pkg::out_item_t r;
    logic                strobe;
    strobe = 1'b0;
    if (it.cmd) begin
      region = 2'(it.saved_value % 8'd3);
      apply_pins();
      lamps = lamp_of(region);
    end else begin
      if (it.button_edge && bounce == 2'd0) begin
        bounce   = DEBOUNCE_PASSES;
        pressing = 1'b1;
      end
      if (it.tick) begin
        if (pressing && held != HOLD_FULL) held = held + 16'd1;
        if (bounce != 2'd0) bounce = bounce - 2'd1;
        if (delay != 8'd0) delay = delay - 8'd1;
      end
      if (pressing && bounce == 2'd0) begin
        if (it.button_pressed) begin
          if (held > shadow_cfg.hold_ticks) showing = 1'b1;
        end else begin
          pressing = 1'b0;
          if (held > shadow_cfg.hold_ticks) begin
            steps      = 5'd0;
            showing    = 1'b0;
            confirming = 1'b1;
          end else begin
            pulsing = 1'b1;
            delay   = shadow_cfg.reset_pulse_ticks;
          end
          held = 16'd0;
        end
      end
      if (showing && delay == 8'd0) begin
        blink_step(shadow_cfg.show_step_limit, 1'b1, strobe);
        delay = shadow_cfg.fast_blink_ticks;
      end
      if (confirming && delay == 8'd0) begin
        blink_step(shadow_cfg.confirm_step_limit, 1'b0, strobe);
        delay = shadow_cfg.slow_blink_ticks;
      end
      if (pulsing) begin
        if (delay != 8'd0) begin
          rst_line = 1'b0;
        end else begin
          rst_line = 1'b1;
          pulsing  = 1'b0;
        end
      end
    end
    r.led_red          = lamps[0] ^ shadow_cfg.led_common_anode;
    r.led_green        = lamps[1] ^ shadow_cfg.led_common_anode;
    r.led_blue         = lamps[2] ^ shadow_cfg.led_common_anode;
    r.video_pin        = pins[0];
    r.language_pin     = pins[1];
    r.inv_video_pin    = pins[2];
    r.inv_language_pin = pins[3];
    r.reset_out        = rst_line;
    r.save_strobe      = strobe;
    r.current_region   = region;
    expected_outputs.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [1:0] got,
                                 input logic [1:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic compare_outputs(input rsbc_pkg::out_item_t got);
    rsbc_pkg::out_item_t want;
    if (expected_outputs.size() == 0) begin
      report_mismatch("unexpected transaction", 2'd0, 2'd0);
    end else begin
      want = expected_outputs.pop_front();
      check_field("led_red", 2'(got.led_red), 2'(want.led_red));
      check_field("led_green", 2'(got.led_green), 2'(want.led_green));
      check_field("led_blue", 2'(got.led_blue), 2'(want.led_blue));
      check_field("video_pin", 2'(got.video_pin), 2'(want.video_pin));
      check_field("language_pin", 2'(got.language_pin), 2'(want.language_pin));
      check_field("inv_video_pin", 2'(got.inv_video_pin), 2'(want.inv_video_pin));
      check_field("inv_language_pin", 2'(got.inv_language_pin),
                  2'(want.inv_language_pin));
      check_field("reset_out", 2'(got.reset_out), 2'(want.reset_out));
      check_field("save_strobe", 2'(got.save_strobe), 2'(want.save_strobe));
      check_field("current_region", got.current_region, want.current_region);
    end
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      compare_outputs(res_ch.payload);
      @(negedge clk);
    end
  end

  task automatic send_pass(input rsbc_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    update_selector(it);
    passes_sent++;
  endtask

  task automatic poll(input bit tick, input bit button_edge, input bit pressed);
    rsbc_pkg::in_item_t it;
    it                = InItemBits'($urandom);
    it.cmd            = 1'b0;
    it.tick           = tick;
    it.button_edge    = button_edge;
    it.button_pressed = pressed;
    send_pass(it);
  endtask

  task automatic boot_load(input logic [7:0] saved);
    rsbc_pkg::in_item_t it;
    it             = InItemBits'($urandom);
    it.cmd         = 1'b1;
    it.saved_value = saved;
    send_pass(it);
  endtask

  task automatic press_cycle(input int hold_passes, input int after_passes, input int tick_pct);
    poll($urandom_range(0, 99) < tick_pct, 1'b1, 1'b1);
    repeat (hold_passes) poll($urandom_range(0, 99) < tick_pct, $urandom_range(0, 9) == 0, 1'b1);
    repeat (after_passes) poll($urandom_range(0, 99) < tick_pct, 1'b0, 1'b0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rsbc_pkg::CfgIndexBits-1:0] index,
                           input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      rsbc_pkg::REG_ADDON_MODE:         shadow_cfg.addon_mode         = value[0];
      rsbc_pkg::REG_LED_COMMON_ANODE:   shadow_cfg.led_common_anode   = value[0];
      rsbc_pkg::REG_HOLD_TICKS:         shadow_cfg.hold_ticks         = value;
      rsbc_pkg::REG_FAST_BLINK_TICKS:   shadow_cfg.fast_blink_ticks   = value[7:0];
      rsbc_pkg::REG_SLOW_BLINK_TICKS:   shadow_cfg.slow_blink_ticks   = value[7:0];
      rsbc_pkg::REG_RESET_PULSE_TICKS:  shadow_cfg.reset_pulse_ticks  = value[7:0];
      rsbc_pkg::REG_SHOW_STEP_LIMIT:    shadow_cfg.show_step_limit    = value[4:0];
      rsbc_pkg::REG_CONFIRM_STEP_LIMIT: shadow_cfg.confirm_step_limit = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 16'd1 : (r == 1) ? 16'd255 : 16'($urandom_range(1, 4));
  endfunction

  function automatic logic [15:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 16'd0 : (r == 1) ? 16'd30 : 16'($urandom_range(0, 5));
  endfunction

  task automatic test_boot_load();
    boot_load(8'h00);
    boot_load(8'hFF);
    boot_load(8'h01);
    boot_load(8'h02);
    boot_load(8'h80);
    write_reg(rsbc_pkg::REG_ADDON_MODE, 16'd1);
    write_reg(rsbc_pkg::REG_RESET_PULSE_TICKS, 16'd2);
    boot_load(8'hAA);
    repeat (3) poll(1'b1, 1'b0, 1'b0);
    write_reg(rsbc_pkg::REG_ADDON_MODE, 16'd0);
  endtask

  task automatic test_short_press();
    write_reg(rsbc_pkg::REG_HOLD_TICKS, 16'd10);
    write_reg(rsbc_pkg::REG_RESET_PULSE_TICKS, 16'd3);
    poll(1'b1, 1'b1, 1'b1);
    poll(1'b0, 1'b1, 1'b1);
    repeat (2) poll(1'b1, 1'b0, 1'b1);
    repeat (5) poll(1'b1, 1'b0, 1'b0);
    write_reg(rsbc_pkg::REG_RESET_PULSE_TICKS, 16'd1);
    press_cycle(2, 3, 100);
  endtask

  task automatic test_select_and_confirm();
    write_reg(rsbc_pkg::REG_HOLD_TICKS, 16'd2);
    write_reg(rsbc_pkg::REG_FAST_BLINK_TICKS, 16'd1);
    write_reg(rsbc_pkg::REG_SLOW_BLINK_TICKS, 16'd1);
    write_reg(rsbc_pkg::REG_SHOW_STEP_LIMIT, 16'd0);
    write_reg(rsbc_pkg::REG_CONFIRM_STEP_LIMIT, 16'd0);
    write_reg(rsbc_pkg::REG_ADDON_MODE, 16'd1);
    write_reg(rsbc_pkg::REG_RESET_PULSE_TICKS, 16'd4);
    press_cycle(14, 12, 100);
  endtask

  task automatic test_confirm_overlap();
    write_reg(rsbc_pkg::REG_ADDON_MODE, 16'd0);
    write_reg(rsbc_pkg::REG_SLOW_BLINK_TICKS, 16'd2);
    write_reg(rsbc_pkg::REG_CONFIRM_STEP_LIMIT, 16'd3);
    press_cycle(8, 2, 100);
    press_cycle(10, 30, 100);
  endtask

  task automatic test_led_polarity();
    write_reg(rsbc_pkg::REG_LED_COMMON_ANODE, 16'd0);
    boot_load(8'h01);
    poll(1'b0, 1'b0, 1'b0);
    write_reg(rsbc_pkg::REG_LED_COMMON_ANODE, 16'd1);
    poll(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_long_hold();
    idle_on = 1'b0;
    write_reg(rsbc_pkg::REG_HOLD_TICKS, 16'd40);
    write_reg(rsbc_pkg::REG_FAST_BLINK_TICKS, 16'd255);
    poll(1'b1, 1'b1, 1'b1);
    repeat (44) poll(1'b1, 1'b0, 1'b1);
    repeat (4) poll(1'b1, 1'b0, 1'b0);
    write_reg(rsbc_pkg::REG_HOLD_TICKS, 16'hFFFF);
    write_reg(rsbc_pkg::REG_FAST_BLINK_TICKS, 16'd2);
    press_cycle(4, 4, 100);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                 target;
    int                 phase_end;
    int                 pick;
    rsbc_pkg::in_item_t it;
    target = passes_sent + 390;
    while (passes_sent < target) begin
      idle_on = ($urandom_range(0, 4) != 0);
      write_reg(rsbc_pkg::REG_ADDON_MODE, 16'($urandom_range(0, 1)));
      write_reg(rsbc_pkg::REG_LED_COMMON_ANODE, 16'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      write_reg(rsbc_pkg::REG_HOLD_TICKS, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                16'($urandom_range(1, 8)));
      write_reg(rsbc_pkg::REG_FAST_BLINK_TICKS, pick_delay());
      write_reg(rsbc_pkg::REG_SLOW_BLINK_TICKS, pick_delay());
      write_reg(rsbc_pkg::REG_RESET_PULSE_TICKS, pick_delay());
      write_reg(rsbc_pkg::REG_SHOW_STEP_LIMIT, pick_limit());
      write_reg(rsbc_pkg::REG_CONFIRM_STEP_LIMIT, pick_limit());
      phase_end = passes_sent + 60;
      while (passes_sent < phase_end && passes_sent < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          press_cycle($urandom_range(0, 25), $urandom_range(0, 40), $urandom_range(50, 100));
        end else if (pick == 7) begin
          boot_load(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            it     = InItemBits'($urandom);
            it.cmd = 1'b0;
            send_pass(it);
          end
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : run_tests
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    cfg_we          = 1'b0;
    cfg_index       = rsbc_pkg::REG_ADDON_MODE;
    cfg_data        = '0;
    rst             = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_boot_load();
    test_short_press();
    test_select_and_confirm();
    test_confirm_overlap();
    test_led_polarity();
    test_long_hold();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ region_switch_button_controller_core.f @@
+incdir+rtl
rtl/rsbc_pkg.sv
rtl/rsbc_stream_if.sv
rtl/rsbc_cfg.sv
rtl/rsbc_step.sv
rtl/region_switch_button_controller_core.sv
tb/tb_region_switch_button_controller_core.sv
